[rtl/core/ordered_distinct_filter_defines.svh]
// Assertion macros for the ordered distinct filter.
// Needs a clk and an active-low rst_n in the scope of every use.
`ifndef ORDERED_DISTINCT_FILTER_DEFINES_SVH
`define ORDERED_DISTINCT_FILTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ODF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ODF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/odf_pkg.sv]
// Shared types and constants of the ordered distinct filter.
// No dependencies.
`timescale 1ns / 1ps

package odf_pkg;

  localparam int VALUE_W      = 32;
  localparam int TABLE_BITS_W = 4;
  localparam int BITS_W       = 5;
  localparam int EPOCH_W      = 8;

  localparam logic [TABLE_BITS_W-1:0] TABLE_BITS_RST = 4'd12;
  localparam logic [VALUE_W-1:0]      HASH_MULT      = 32'h9E37_79B9;
  localparam logic [VALUE_W-1:0]      KEY_MIN        = 32'h8000_0000;
  localparam logic [EPOCH_W-1:0]      EPOCH_FIRST    = 8'd1;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value_out;
    logic                      first_seen;
    logic                      end_of_array;
    logic                      table_full;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_HASH  = 4'b0100,
    ST_PROBE = 4'b1000
  } odf_state_t;

endpackage

[rtl/core/odf_hash.sv]
// Multiplicative hash: registered 32x32 product, then top-bits slot select.
// Depends on odf_pkg.
`timescale 1ns / 1ps

module odf_hash import odf_pkg::*; #(
  parameter int AW = 12
) (
  input  logic               clk,
  input  logic               load,
  input  logic [VALUE_W-1:0] value,
  input  logic [BITS_W-1:0]  bits,
  output logic [AW-1:0]      idx
);

  logic [VALUE_W-1:0]   key;
  logic [VALUE_W-1:0]   prod_lo;
  logic [VALUE_W-1:0]   prod_r;
  logic [VALUE_W-1:0]   shifted;

  // Most negative value hashes as zero.
  assign key     = (value == KEY_MIN) ? '0 : value;
  // Only the low word of the product feeds the slot select.
  assign prod_lo = key * HASH_MULT;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_lo;
    end
  end

  // Keep the top bits of the product.
  assign shifted = prod_r >> (6'd32 - {1'b0, bits});
  assign idx     = shifted[AW-1:0];

endmodule

[rtl/core/odf_slot_ram.sv]
// Slot store: single write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module odf_slot_ram #(
  parameter int AW = 12,
  parameter int DW = 40
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/ordered_distinct_filter.sv]
// Ordered distinct filter: marks the first appearance of each value in an array.
// Each item takes a hash state, then probes from its home slot at most once per
// slot of the active table, one probe a cycle (single read port) unless the
// output stalls; the result register is valid on the edge after the last probe.
// A new item may enter in the cycle that retires the current one. Reset (sync,
// active low) sweeps all 2^MAX_TABLE_LOG2 slots free, as does each 255th array.
`timescale 1ns / 1ps
`include "ordered_distinct_filter_defines.svh"

module ordered_distinct_filter import odf_pkg::*; #(
  parameter int MAX_TABLE_LOG2 = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  in_item_t                in_item,
  output logic                    in_stall,
  output logic                    out_valid,
  output out_item_t               out_item,
  input  logic                    out_stall,
  input  logic                    cfg_we,
  input  logic [TABLE_BITS_W-1:0] cfg_wdata
);

  localparam int AW = MAX_TABLE_LOG2;
  localparam int DW = EPOCH_W + VALUE_W;
  localparam logic [BITS_W-1:0] MAX_BITS = BITS_W'(MAX_TABLE_LOG2);

  // Control and datapath registers.
  odf_state_t               state_r, state_nxt;
  logic [TABLE_BITS_W-1:0]  tbl_bits_r;
  logic [EPOCH_W-1:0]       epoch_r, epoch_nxt;
  logic [AW-1:0]            clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic [AW-1:0]            cnt_r, cnt_nxt;
  logic [VALUE_W-1:0]       cur_value_r;
  logic                     cur_last_r;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_item_r, out_item_nxt;

  // Slot lookup.
  logic [BITS_W-1:0]        act_bits;
  logic [AW-1:0]            mask;
  logic [AW-1:0]            hash_idx;
  logic [AW-1:0]            rd_addr;
  logic [DW-1:0]            rd_data;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [DW-1:0]            wr_data;
  logic [EPOCH_W-1:0]       rd_epoch;
  logic [VALUE_W-1:0]       rd_value;

  // Probe outcome.
  logic                     slot_used;
  logic                     hit;
  logic                     miss_free;
  logic                     exhausted;
  logic                     probe_done;
  logic                     out_free;
  logic                     finish;
  logic                     wrap;
  logic                     accept;

  // Clamp the configured size to 1 .. MAX_TABLE_LOG2.
  always_comb begin
    if (tbl_bits_r == '0) begin
      act_bits = BITS_W'(1);
    end else if ({1'b0, tbl_bits_r} > MAX_BITS) begin
      act_bits = MAX_BITS;
    end else begin
      act_bits = {1'b0, tbl_bits_r};
    end
  end

  assign mask = ~({AW{1'b1}} << act_bits);

  // A slot is in use only if it carries the current array's epoch, so the end
  // of an array frees every slot by a new epoch, or by a sweep after epoch 255.
  assign rd_epoch   = rd_data[DW-1 -: EPOCH_W];
  assign rd_value   = rd_data[VALUE_W-1:0];
  assign slot_used  = (rd_epoch == epoch_r);
  assign hit        = slot_used && (rd_value == cur_value_r);
  assign miss_free  = !slot_used;
  assign exhausted  = slot_used && !hit && (cnt_r == mask);
  assign probe_done = hit || miss_free || exhausted;

  // The output register frees up when it is empty or taken this cycle.
  assign out_free = !out_valid_r || !out_stall;
  assign finish   = (state_r == ST_PROBE) && probe_done && out_free;
  assign wrap     = cur_last_r && (epoch_r == {EPOCH_W{1'b1}});

  // Take a new item when idle, or in the cycle that retires the current one.
  assign in_stall = !((state_r == ST_IDLE) || (finish && !wrap));
  assign accept   = in_valid && !in_stall;

  odf_hash #(
    .AW (AW)
  ) u_hash (
    .clk   (clk),
    .load  (accept),
    .value (in_item.value),
    .bits  (act_bits),
    .idx   (hash_idx)
  );

  odf_slot_ram #(
    .AW (AW),
    .DW (DW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    epoch_nxt     = epoch_r;
    clr_addr_nxt  = clr_addr_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    rd_addr       = idx_r;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = {epoch_r, cur_value_r};

    case (state_r)
      ST_CLEAR: begin
        // Sweep: mark every slot with the reserved free epoch.
        wr_en        = 1'b1;
        wr_addr      = clr_addr_r;
        wr_data      = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == {AW{1'b1}}) begin
          epoch_nxt = EPOCH_FIRST;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_HASH;
        end
      end
      ST_HASH: begin
        // Issue the first probe at the home slot.
        rd_addr   = hash_idx;
        idx_nxt   = hash_idx;
        cnt_nxt   = '0;
        state_nxt = ST_PROBE;
      end
      ST_PROBE: begin
        if (finish) begin
          // Claim the free slot, load the result, retire the item.
          wr_en                     = miss_free;
          out_valid_nxt             = 1'b1;
          out_item_nxt.value_out    = cur_value_r;
          out_item_nxt.first_seen   = miss_free;
          out_item_nxt.end_of_array = cur_last_r;
          out_item_nxt.table_full   = exhausted;
          if (wrap) begin
            clr_addr_nxt = '0;
            state_nxt    = ST_CLEAR;
          end else begin
            if (cur_last_r) begin
              epoch_nxt = epoch_r + 1'b1;
            end
            state_nxt = accept ? ST_HASH : ST_IDLE;
          end
        end else if (!probe_done) begin
          // Advance to the next slot, wrapping inside the active table.
          idx_nxt = (idx_r + 1'b1) & mask;
          cnt_nxt = cnt_r + 1'b1;
          rd_addr = idx_nxt;
        end
        // Otherwise hold: the result waits for the output register, and the
        // same slot is read again.
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      tbl_bits_r  <= TABLE_BITS_RST;
      epoch_r     <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      epoch_r     <= epoch_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        tbl_bits_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    out_item_r <= out_item_nxt;
    if (accept) begin
      cur_value_r <= in_item.value;
      cur_last_r  <= in_item.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `ODF_ASSERT_NOW(a_no_take_in_clear, state_r == ST_CLEAR, in_stall, "item taken during sweep")
  `ODF_ASSERT_NOW(a_epoch_live, state_r != ST_CLEAR, epoch_r != '0, "free epoch used as live")
  `ODF_ASSERT_NEXT(a_finish_loads, finish, out_valid_r, "retired item left no result")
  `ODF_ASSERT_NOW(a_flags_excl, out_valid_r, !(out_item_r.first_seen && out_item_r.table_full), "new and full together")
  `ODF_ASSERT_NOW(a_probe_bound, state_r == ST_PROBE, (cnt_r & ~mask) == '0, "probe count past table size")

endmodule

[sim/ordered_distinct_filter_tb.sv]
// Self-checking bench for ordered_distinct_filter: hash-set dedup with linear probing.
// Depends on odf_pkg (item types, reset and hash constants) and the filter RTL only.
`timescale 1ns / 1ps

module ordered_distinct_filter_tb;
  import odf_pkg::*;

  localparam int SLOTS_LOG2   = 12;
  localparam int SLOTS        = 1 << SLOTS_LOG2;
  localparam int REPORT_LIMIT = 10;
  localparam int LONG_HOLD    = 400;
  localparam int ROUNDS       = 18;
  localparam int ROUND_ITEMS  = 38;

  // Shadow hash table: predicts first_seen / table_full per item and checks
  // results in order.
  class dedup_scoreboard;
    logic [TABLE_BITS_W-1:0] table_bits;
    bit                      slot_used[SLOTS];
    logic [VALUE_W-1:0]      slot_value[SLOTS];
    out_item_t               pending_results[$];
    int                      mismatches;

    function new();
      table_bits = TABLE_BITS_RST;
      mismatches = 0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
    endfunction

    function void set_table_bits(logic [TABLE_BITS_W-1:0] bits);
      table_bits = bits;
    endfunction

    // Probe from the hashed home slot, store on first sight, clear on last.
    function void note_item(in_item_t item);
      int unsigned        bits, size, mask, slot, probes;
      logic [VALUE_W-1:0] key, prod;
      bit                 found, have_free;
      out_item_t          res;
      bits = (table_bits < 1) ? 1 : (table_bits > SLOTS_LOG2) ? SLOTS_LOG2 : table_bits;
      size = 1 << bits;
      mask = size - 1;
      // the most negative value hashes as zero, but compares as itself
      key  = (item.value == KEY_MIN) ? '0 : item.value;
      prod = key * HASH_MULT;
      slot = (prod >> (32 - bits)) & mask;
      found = 1'b0;
      have_free = 1'b0;
      for (probes = 0; probes < size; probes++) begin
        if (!slot_used[slot]) begin
          have_free = 1'b1;
          break;
        end
        if (slot_value[slot] == item.value) begin
          found = 1'b1;
          break;
        end
        slot = (slot + 1) & mask;
      end
      res.value_out    = item.value;
      res.first_seen   = 1'b0;
      res.end_of_array = item.last;
      res.table_full   = 1'b0;
      if (!found) begin
        if (have_free) begin
          slot_used[slot]  = 1'b1;
          slot_value[slot] = item.value;
          res.first_seen   = 1'b1;
        end else begin
          res.table_full = 1'b1;
        end
      end
      if (item.last) foreach (slot_used[i]) slot_used[i] = 1'b0;
      pending_results.push_back(res);
    endfunction

    function void check_item(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] result with nothing pending: value %0d", $time, got.value_out);
        return;
      end
      want = pending_results.pop_front();
      if (got.value_out !== want.value_out || got.first_seen !== want.first_seen ||
          got.end_of_array !== want.end_of_array || got.table_full !== want.table_full) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("[%0t] mismatch: exp %0d/%b/%b/%b got %0d/%b/%b/%b (val/first/end/full)",
                   $time, want.value_out, want.first_seen, want.end_of_array, want.table_full,
                   got.value_out, got.first_seen, got.end_of_array, got.table_full);
      end
    endfunction
  endclass

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  in_item_t                in_item   = '0;
  logic                    in_stall;
  logic                    out_valid;
  out_item_t               out_item;
  logic                    out_stall = 1'b0;
  logic                    cfg_we    = 1'b0;
  logic [TABLE_BITS_W-1:0] cfg_wdata = '0;

  dedup_scoreboard    sb;
  int                 snd_idle_pct = 0;
  int                 rcv_idle_pct = 0;
  int                 hold_reqs    = 0;
  int                 hold_seen    = 0;
  int                 hold_left    = 0;
  logic [VALUE_W-1:0] value_pool[16];
  int                 pool_n       = 1;
  int                 array_left   = 0;

  ordered_distinct_filter #(
    .MAX_TABLE_LOG2(SLOTS_LOG2)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case the filter hangs: far beyond the slowest legal run,
  // including the post-reset clearing sweep and the long receiver hold.
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver back-pressure: a requested long hold wins over random stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_reqs != hold_seen || hold_left > 0) begin
      if (hold_reqs != hold_seen) begin
        hold_left = LONG_HOLD;
        hold_seen = hold_reqs;
      end
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // Sample mid-cycle: out_stall and the result are stable, and the item is
  // taken at the coming rising edge.
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_item(out_item);
  end

  // Offer one item after idling a random number of cycles; return at the
  // accepting edge.
  task automatic send_item(input logic signed [VALUE_W-1:0] value, input logic is_last);
    in_item_t item;
    while (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    item.value = value;
    item.last  = is_last;
    in_valid <= 1'b1;
    in_item  <= item;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    sb.note_item(item);
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_table_bits(input logic [TABLE_BITS_W-1:0] bits);
    cfg_we    <= 1'b1;
    cfg_wdata <= bits;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_table_bits(bits);
  endtask

  // Draw values mostly from a small per-array pool so that repeats, hash
  // collisions and full tables are common; the rest is fully random.
  task automatic send_random_item();
    logic signed [VALUE_W-1:0] v;
    int                        i;
    if (array_left == 0) begin
      array_left = $urandom_range(1, 40);
      pool_n     = $urandom_range(1, 16);
      for (i = 0; i < pool_n; i++) begin
        case ($urandom_range(5))
          0:       value_pool[i] = KEY_MIN;
          1:       value_pool[i] = '0;
          2:       value_pool[i] = 32'h7FFF_FFFF;
          3:       value_pool[i] = $urandom_range(15);
          4:       value_pool[i] = -$urandom_range(1, 15);
          default: value_pool[i] = $urandom;
        endcase
      end
    end
    v = ($urandom_range(3) == 0) ? $urandom : value_pool[$urandom_range(pool_n - 1)];
    array_left--;
    send_item(v, array_left == 0);
  endtask

  initial begin
    int r, k;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset size (4096 slots): extremes, repeats, and the most negative value
    // colliding with zero on the hash but not on equality.
    send_item(0, 1'b0);
    send_item(KEY_MIN, 1'b0);
    send_item(32'sh7FFF_FFFF, 1'b0);
    send_item(-1, 1'b0);
    send_item(0, 1'b0);
    send_item(KEY_MIN, 1'b0);
    send_item(32'sh7FFF_FFFF, 1'b1);
    // table cleared after last: zero is new again
    send_item(0, 1'b1);

    // Two slots: fill up, then a new value reports full, a known one does not.
    drain();
    write_table_bits(4'd1);
    send_item(5, 1'b0);
    send_item(6, 1'b0);
    send_item(7, 1'b0);
    send_item(5, 1'b0);
    send_item(7, 1'b1);

    // Size below range clamps to two slots.
    drain();
    write_table_bits(4'd0);
    send_item(-1, 1'b0);
    send_item(KEY_MIN, 1'b0);
    send_item(0, 1'b0);
    send_item(KEY_MIN, 1'b1);

    // Size above range clamps to the maximum; then shrink mid-array so that
    // stored values may be missed and flagged again.
    drain();
    write_table_bits(4'd15);
    send_item(3, 1'b0);
    send_item(4, 1'b0);
    drain();
    write_table_bits(4'd2);
    send_item(3, 1'b0);
    send_item(4, 1'b0);
    send_item(9, 1'b0);
    send_item(3, 1'b1);
    drain();
    write_table_bits(4'd12);

    // Random rounds: each starts drained with a new size, so arrays that span
    // a round boundary see a mid-array size change.
    for (r = 0; r < ROUNDS; r++) begin
      snd_idle_pct = (r < 6) ? 17 : (r < 12) ? 61 : 0;
      rcv_idle_pct = (r < 6) ? 61 : (r < 12) ? 17 : 0;
      drain();
      if ($urandom_range(1)) write_table_bits(TABLE_BITS_W'($urandom_range(1, 3)));
      else write_table_bits(TABLE_BITS_W'($urandom_range(15)));
      // hold the receiver off long enough to back the filter up to its input
      if (r == 2 || r == 14) hold_reqs++;
      for (k = 0; k < ROUND_ITEMS; k++) send_random_item();
    end

    drain();
    repeat (32) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
